>>> src/aes_pkg.sv
// shared types and constants for the static arithmetic encoder
package aes_pkg;

	typedef enum logic [1:0] {
		ACT_LOAD   = 2'd0,
		ACT_ENCODE = 2'd1,
		ACT_FINISH = 2'd2,
		ACT_NONE   = 2'd3
	} action_t;

	typedef struct packed {
		logic [1:0] action;
		logic [7:0] symbol;
		logic [7:0] freq;
	} in_word_t;

	typedef struct packed {
		logic        has_bit;
		logic        out_bit;
		logic [15:0] follow_count;
		logic        error;
		logic        last;
	} out_word_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LOAD_RD,
		ST_ENC_RD0,
		ST_ENC_RD1,
		ST_ENC_CHK,
		ST_MUL,
		ST_DIV_GO,
		ST_DIV,
		ST_NARROW,
		ST_RENORM,
		ST_EMIT,
		ST_REJECT,
		ST_FLUSH
	} state_t;

	localparam logic [15:0] PEND_MAX   = 16'hFFFF;
	localparam logic [15:0] FLUSH_PEND = 16'd8;

endpackage

>>> src/aes_div.sv
// restoring divider, one quotient bit per cycle
module aes_div #(
	parameter int NUM_W = 48,
	parameter int DEN_W = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output logic [NUM_W-1:0] quo
);
	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [NUM_W-1:0] quo_q;
	logic [DEN_W:0]   rem_q;
	logic [DEN_W-1:0] den_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic [DEN_W:0]   trial;
	logic [DEN_W:0]   diff;

	// shift in next numerator bit and try a subtract
	always_comb begin
		trial = {rem_q[DEN_W-1:0], quo_q[NUM_W-1]};
		diff  = trial - {1'b0, den_q};
	end

	// busy and count; done flags the finished quotient once the count reaches zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(NUM_W);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q && cnt_q != '0) begin
			if (!diff[DEN_W]) begin
				rem_q <= diff;
				quo_q <= {quo_q[NUM_W-2:0], 1'b1};
			end else begin
				rem_q <= trial;
				quo_q <= {quo_q[NUM_W-2:0], 1'b0};
			end
		end
	end

	assign done = busy_q && (cnt_q == '0);
	assign quo  = quo_q;
endmodule

>>> src/aes_table.sv
// cumulative frequency table memory, one port, registered read
module aes_table #(
	parameter int DEPTH = 257,
	parameter int ADDR_W = 9
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] addr,
	input  logic [15:0]       wdata,
	output logic [15:0]       rdata
);
	logic [15:0] mem [DEPTH];

	// read first: a read during a write returns the old word
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule

>>> src/arithmetic_encoder_static.sv
// static-model arithmetic encoder top level
//
//  channel | handshake             | word
//  in      | in_valid / in_ready   | aes_pkg::in_word_t (action, symbol, freq)
//  out     | out_valid / out_ready | aes_pkg::out_word_t (bit records)
//
// load and an unused action return to idle; finish waits until the output register is free
// encode reads the table, forms products and runs two sequential divisions up to the narrowed
//   interval; a rejected encode ends sooner
// renormalization then handles underflow steps and settled bits in turn before it closes;
//   each bit record is held back one step so its last flag is known
// a full output register stalls the coder in place; reset clears the coder and sum,
//   not the table memory
module arithmetic_encoder_static #(
	parameter int NUM_SYMBOLS = 256,
	parameter int CODE_BITS   = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  aes_pkg::in_word_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output aes_pkg::out_word_t out_data
);
	import aes_pkg::*;

	localparam int ADDR_W = $clog2(NUM_SYMBOLS + 1);
	localparam int PROD_W = CODE_BITS + 1 + 16;
	localparam logic [CODE_BITS-1:0] CMASK = '1;
	localparam logic [CODE_BITS-1:0] QTR   = CODE_BITS'(1) << (CODE_BITS - 2);
	localparam logic [CODE_BITS-1:0] HALF  = CODE_BITS'(2) << (CODE_BITS - 2);
	localparam logic [CODE_BITS-1:0] TQTR  = CODE_BITS'(3) << (CODE_BITS - 2);

	state_t state_q, state_d;
	in_word_t        cur_q;
	logic [15:0]     sum_q;
	logic [CODE_BITS-1:0] low_q, high_q;
	logic [15:0]     pend_q;
	logic [15:0]     c0_q, c1_q;
	logic [CODE_BITS:0] range_q;
	logic [PROD_W-1:0] prod_lo_q, prod_hi_q;
	logic [PROD_W-1:0] q0_q;
	logic            div_sel_q;
	logic            any_q;
	out_word_t       hold_q;
	out_word_t       obuf_q;
	logic            ovalid_q;

	logic              mem_we;
	logic [ADDR_W-1:0] mem_addr;
	logic [15:0]       mem_wdata, mem_rdata;
	logic              div_start, div_done;
	logic [PROD_W-1:0] div_num, div_quo;

	logic sym_ok;
	logic [15:0] sum_next;
	logic [CODE_BITS:0] nlo_w, nhi_w;
	logic ren_zero, ren_one, ren_under;
	logic emit_now;
	logic load_out;
	logic [15:0] pend_inc, pend_fl;

	assign sym_ok   = 32'(cur_q.symbol) < NUM_SYMBOLS;
	assign sum_next = ((cur_q.symbol == 8'd0) ? 16'd0 : sum_q) + 16'(cur_q.freq);
	assign ren_zero  = high_q < HALF;
	assign ren_one   = !ren_zero && low_q >= HALF;
	assign ren_under = !ren_zero && !ren_one && low_q >= QTR && high_q < TQTR;
	assign pend_inc  = (pend_q == PEND_MAX) ? PEND_MAX : pend_q + 16'd1;
	assign pend_fl   = (pend_q > PEND_MAX - FLUSH_PEND) ? PEND_MAX : pend_q + FLUSH_PEND;
	assign nlo_w = {1'b0, low_q} + (CODE_BITS+1)'(q0_q);
	assign nhi_w = {1'b0, low_q} + (CODE_BITS+1)'(div_quo);
	assign emit_now = !ovalid_q || out_ready;
	assign load_out = emit_now && ((state_q == ST_EMIT && any_q) ||
		state_q == ST_REJECT || state_q == ST_FLUSH);

	// table memory
	aes_table #(.DEPTH(NUM_SYMBOLS + 1), .ADDR_W(ADDR_W)) u_table (
		.clk(clk), .we(mem_we), .addr(mem_addr), .wdata(mem_wdata), .rdata(mem_rdata)
	);

	// shared divider for both interval bounds
	aes_div #(.NUM_W(PROD_W), .DEN_W(16)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(div_num),
		.den(sum_q), .done(div_done), .quo(div_quo)
	);

	// low product first, high product when started from the divide state
	assign div_num = (state_q == ST_DIV) ? prod_hi_q : prod_lo_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					unique case (action_t'(in_data.action))
						ACT_LOAD:   state_d = ST_LOAD_RD;
						ACT_ENCODE: state_d = ST_ENC_RD0;
						ACT_FINISH: state_d = ST_FLUSH;
						ACT_NONE:   state_d = ST_IDLE;
					endcase
				end
			end
			ST_LOAD_RD: state_d = ST_IDLE;
			ST_ENC_RD0: state_d = (!sym_ok || sum_q == 16'd0) ? ST_REJECT : ST_ENC_RD1;
			ST_ENC_RD1: state_d = ST_ENC_CHK;
			ST_ENC_CHK: state_d = ST_MUL;
			ST_MUL: state_d = (c1_q <= c0_q || c1_q > sum_q) ? ST_REJECT : ST_DIV_GO;
			ST_DIV_GO: state_d = ST_DIV;
			ST_DIV: begin
				if (div_done && div_sel_q) begin
					state_d = ST_NARROW;
				end
			end
			// empty interval after narrowing is rejected too
			ST_NARROW: state_d = (nhi_w <= nlo_w) ? ST_REJECT : ST_RENORM;
			ST_RENORM: begin
				if (ren_zero || ren_one) begin
					state_d = ST_EMIT;
				end else if (!ren_under) begin
					state_d = any_q ? ST_EMIT : ST_IDLE;
				end
			end
			ST_EMIT: begin
				if (ren_zero || ren_one) begin
					if (!any_q || emit_now) state_d = ST_RENORM;
				end else if (emit_now) begin
					state_d = ST_IDLE;
				end
			end
			ST_REJECT: if (emit_now) state_d = ST_IDLE;
			ST_FLUSH: if (emit_now) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// memory and divider control
	always_comb begin
		mem_we    = 1'b0;
		mem_addr  = ADDR_W'(cur_q.symbol);
		mem_wdata = sum_next;
		div_start = 1'b0;
		unique case (state_q)
			ST_LOAD_RD: begin
				mem_we   = sym_ok;
				mem_addr = ADDR_W'(cur_q.symbol) + ADDR_W'(1);
			end
			ST_ENC_RD0: mem_addr = ADDR_W'(cur_q.symbol);
			ST_ENC_RD1: mem_addr = ADDR_W'(cur_q.symbol) + ADDR_W'(1);
			ST_DIV_GO:  div_start = 1'b1;
			ST_DIV:     div_start = div_done && !div_sel_q;
			default: ;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			sum_q     <= '0;
			low_q     <= '0;
			high_q    <= CMASK;
			pend_q    <= '0;
			ovalid_q  <= 1'b0;
			div_sel_q <= 1'b0;
			any_q     <= 1'b0;
		end else begin
			state_q  <= state_d;
			ovalid_q <= load_out || (ovalid_q && !out_ready);
			unique case (state_q)
				ST_LOAD_RD: begin
					if (sym_ok) begin
						sum_q <= sum_next;
						if (cur_q.symbol == 8'd0) begin
							low_q  <= '0;
							high_q <= CMASK;
							pend_q <= '0;
						end
					end
				end
				ST_MUL: div_sel_q <= 1'b0;
				ST_DIV: if (div_done) div_sel_q <= 1'b1;
				ST_NARROW: begin
					any_q <= 1'b0;
					// empty interval leaves the coder unchanged
					if (nhi_w > nlo_w) begin
						low_q  <= nlo_w[CODE_BITS-1:0];
						high_q <= nhi_w[CODE_BITS-1:0] - 1'b1;
					end
				end
				ST_RENORM: begin
					if (ren_under) begin
						pend_q <= pend_inc;
						low_q  <= (low_q - QTR) << 1;
						high_q <= ((high_q - QTR) << 1) | CODE_BITS'(1);
					end
				end
				ST_EMIT: begin
					if ((ren_zero || ren_one) && (!any_q || emit_now)) begin
						any_q    <= 1'b1;
						pend_q   <= '0;
						low_q    <= low_q << 1;
						high_q   <= (high_q << 1) | CODE_BITS'(1);
					end
				end
				ST_FLUSH: begin
					if (emit_now) begin
						low_q    <= '0;
						high_q   <= CMASK;
						pend_q   <= '0;
					end
				end
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) cur_q <= in_data;
		// entry zero always reads as a cleared sum
		if (state_q == ST_ENC_RD1) c0_q <= (cur_q.symbol == 8'd0) ? 16'd0 : mem_rdata;
		if (state_q == ST_ENC_CHK) begin
			c1_q    <= mem_rdata;
			range_q <= {1'b0, high_q} - {1'b0, low_q} + 1'b1;
		end
		if (state_q == ST_MUL) begin
			prod_lo_q <= PROD_W'(range_q) * PROD_W'(c0_q);
			prod_hi_q <= PROD_W'(range_q) * PROD_W'(c1_q);
		end
		if (state_q == ST_DIV && div_done && !div_sel_q) q0_q <= div_quo;
		// newest settled bit waits here until the next one or the end shows up
		if (state_q == ST_EMIT && (ren_zero || ren_one) && (!any_q || emit_now))
			hold_q <= '{1'b1, !ren_zero, pend_q, 1'b0, 1'b0};
		if (emit_now) begin
			unique case (state_q)
				ST_EMIT: begin
					if (any_q) begin
						obuf_q <= '{hold_q.has_bit, hold_q.out_bit, hold_q.follow_count,
							hold_q.error, !(ren_zero || ren_one)};
					end
				end
				ST_REJECT: obuf_q <= '{1'b0, 1'b0, 16'd0, 1'b1, 1'b1};
				ST_FLUSH: begin
					obuf_q.has_bit      <= 1'b1;
					obuf_q.out_bit      <= !(low_q < QTR);
					obuf_q.follow_count <= pend_fl;
					obuf_q.error        <= 1'b0;
					obuf_q.last         <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = ovalid_q;
	assign out_data  = obuf_q;

	// output word holds while the receiver stalls
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data));

	// input only taken while idle
	a_in_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> state_q == ST_IDLE);

	// coding interval never inverts
	a_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		low_q <= high_q);
endmodule

>>> tb/aes_checker.sv
// checker for the static arithmetic encoder: watches both channels, predicts records, compares
module aes_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_ready,
	input  aes_pkg::in_word_t  in_data,
	input  logic               out_valid,
	input  logic               out_ready,
	input  aes_pkg::out_word_t out_data,
	output int                 errors,
	output int                 waiting
);
	import aes_pkg::*;

	localparam logic [16:0] QTR    = 17'h04000;
	localparam logic [16:0] HALF   = 17'h08000;
	localparam logic [16:0] THREEQ = 17'h0C000;

	logic [15:0] cum [0:256];
	logic [15:0] total_sum;
	logic [16:0] lo_q, hi_q;
	logic [15:0] pend_q;
	out_word_t   records_q [$];

	assign waiting = records_q.size();

	initial errors = 0;

	// report one mismatch and count it
	task automatic report_mismatch(input string what);
		$display("mismatch at %0t: %s", $time, what);
		errors++;
	endtask

	task automatic push_bit(input logic b);
		out_word_t r;
		r = '0;
		r.has_bit = 1'b1;
		r.out_bit = b;
		r.follow_count = pend_q;
		records_q.push_back(r);
		pend_q = '0;
	endtask

	task automatic add_pending(input int unsigned n);
		int unsigned v;
		v = pend_q + n;
		pend_q = (v > 16'hFFFF) ? 16'hFFFF : v[15:0];
	endtask

	task automatic restart_coder();
		lo_q = '0;
		hi_q = 17'h0FFFF;
		pend_q = '0;
	endtask

	// model one accepted input word and queue its bit records
	task automatic predict_records(input in_word_t w);
		logic [63:0] span, c0, c1, nlo, nhp;
		out_word_t   r;
		int          n_prior;
		bit          ok;
		case (action_t'(w.action))
			ACT_LOAD: begin
				if (w.symbol == 0) begin
					total_sum = '0;
					cum[0] = '0;
					restart_coder();
				end
				total_sum = total_sum + w.freq;
				cum[w.symbol + 1] = total_sum;
			end
			ACT_ENCODE: begin
				ok = total_sum != 0;
				c0 = cum[w.symbol];
				c1 = cum[w.symbol + 1];
				if (ok && (c1 <= c0 || c1 > total_sum)) ok = 0;
				if (ok) begin
					span = hi_q - lo_q + 1;
					nlo = lo_q + (span * c0) / total_sum;
					nhp = lo_q + (span * c1) / total_sum;
					if (nhp <= nlo) ok = 0;
				end
				if (!ok) begin
					r = '0;
					r.error = 1'b1;
					r.last = 1'b1;
					records_q.push_back(r);
				end else begin
					n_prior = records_q.size();
					lo_q = nlo[15:0];
					hi_q = {1'b0, nhp[15:0] - 16'd1};
					forever begin
						if (hi_q < HALF) push_bit(1'b0);
						else if (lo_q >= HALF) push_bit(1'b1);
						else if (lo_q >= QTR && hi_q < THREEQ) begin
							add_pending(1);
							lo_q -= QTR;
							hi_q -= QTR;
						end else break;
						lo_q = {1'b0, lo_q[14:0], 1'b0};
						hi_q = {1'b0, hi_q[14:0], 1'b1};
					end
					if (records_q.size() > n_prior)
						records_q[records_q.size() - 1].last = 1'b1;
				end
			end
			ACT_FINISH: begin
				add_pending(8);
				push_bit(lo_q >= QTR);
				records_q[records_q.size() - 1].last = 1'b1;
				restart_coder();
			end
			default: ;
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		out_word_t exp_w;
		if (!arst_n) begin
			total_sum = '0;
			restart_coder();
		end else begin
			// compare outgoing words against the oldest prediction
			if (out_valid && out_ready) begin
				if (records_q.size() == 0)
					report_mismatch("record with nothing expected");
				else begin
					exp_w = records_q.pop_front();
					if (out_data.has_bit !== exp_w.has_bit)
						report_mismatch("has_bit");
					if (out_data.out_bit !== exp_w.out_bit)
						report_mismatch("out_bit");
					if (out_data.follow_count !== exp_w.follow_count)
						report_mismatch($sformatf("follow_count got %0d exp %0d",
							out_data.follow_count, exp_w.follow_count));
					if (out_data.error !== exp_w.error)
						report_mismatch("error");
					if (out_data.last !== exp_w.last)
						report_mismatch("last");
				end
			end
			if (in_valid && in_ready)
				predict_records(in_data);
		end
	end
endmodule

>>> tb/tb.sv
// testbench top for the static arithmetic encoder: stimulus, flow control and verdict
module tb;
	import aes_pkg::*;

	localparam int WATCHDOG = 20000;

	logic      clk = 0;
	logic      arst_n = 0;
	logic      in_valid = 0;
	logic      in_ready;
	in_word_t  in_data = '0;
	logic      out_valid;
	logic      out_ready = 0;
	out_word_t out_data;
	int        errors, waiting;
	int        idle_cycles = 0;
	bit        hold_off = 0;
	int        nsym;
	logic [7:0] freqs [0:255];

	arithmetic_encoder_static uut (.*);

	aes_checker chk (.*);

	always #1 clk = ~clk;

	// send one word, sometimes after a random gap; valid stays up between burst words
	task automatic send_word(input action_t a, input logic [7:0] s, input logic [7:0] f);
		in_word_t w;
		w.action = a;
		w.symbol = s;
		w.freq = f;
		if ($urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		in_data <= w;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
	endtask

	// load a table of n symbols; zero frequencies allowed past symbol 0
	task automatic load_table(input int n, input bit zeros);
		for (int i = 0; i < n; i++) begin
			freqs[i] = zeros && $urandom_range(0, 3) == 0 ? 8'd0 : 8'($urandom_range(1, 255));
			if (i == 0 && freqs[0] == 0) freqs[0] = 8'd1;
			send_word(ACT_LOAD, i[7:0], freqs[i]);
		end
	endtask

	// receiver stall pattern
	initial begin
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_off) out_ready <= 1'b0;
			else out_ready <= ($urandom_range(0, 4) != 0);
		end
	end

	// long receiver hold-off while the sender keeps offering
	initial begin
		@(posedge arst_n);
		repeat (3000) @(posedge clk);
		hold_off = 1;
		repeat (600) @(posedge clk);
		hold_off = 0;
	end

	// watchdog on cycles without any handshake
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WATCHDOG) begin
			$display("FAIL arithmetic_encoder_static");
			$finish;
		end
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// directed: extremes, zero frequency, finish, unused action, zero total
		send_word(ACT_LOAD, 8'd0, 8'd255);
		send_word(ACT_LOAD, 8'd1, 8'd0);
		send_word(ACT_LOAD, 8'd2, 8'd1);
		send_word(ACT_ENCODE, 8'd0, 8'hAA);
		send_word(ACT_ENCODE, 8'd1, 8'h55);
		send_word(ACT_ENCODE, 8'd2, 8'hFF);
		send_word(ACT_ENCODE, 8'd2, 8'h00);
		send_word(ACT_NONE, 8'hFF, 8'hFF);
		send_word(ACT_FINISH, 8'd0, 8'd0);
		send_word(ACT_FINISH, 8'hFF, 8'hFF);
		send_word(ACT_LOAD, 8'd0, 8'd0);
		send_word(ACT_ENCODE, 8'd0, 8'd0);
		// random sessions: small tables, many encodes, some finishes
		for (int sess = 0; sess < 5; sess++) begin
			nsym = $urandom_range(2, 12);
			load_table(nsym, 1);
			for (int k = 0; k < 20; k++) begin
				case ($urandom_range(0, 19))
					0: send_word(ACT_FINISH, 8'($urandom), 8'($urandom));
					1: send_word(ACT_NONE, 8'($urandom), 8'($urandom));
					default: send_word(ACT_ENCODE, 8'($urandom_range(0, nsym - 1)),
						8'($urandom));
				endcase
			end
			send_word(ACT_FINISH, 8'd0, 8'd0);
		end
		in_valid <= 1'b0;
		// keep the queue moving while draining
		while (waiting != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (errors == 0)
			$display("PASS arithmetic_encoder_static");
		else
			$display("FAIL arithmetic_encoder_static");
		$finish;
	end
endmodule

>>> sim.f
src/aes_pkg.sv
src/aes_div.sv
src/aes_table.sv
src/arithmetic_encoder_static.sv
tb/aes_checker.sv
tb/tb.sv
